@@ design/parf_pkg.sv @@
// Shared types and constants for the port and address range filter.
`default_nettype none
package parf_pkg;
    localparam int MAX_RANGES_DEF = 64;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_REVERSED = 2'd2
    } status_t;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic CFG_PORT_LOW  = 1'b0;
    localparam logic CFG_PORT_HIGH = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [15:0] query_port;
        logic [31:0] query_addr;
    } in_item_t;

    typedef struct packed {
        logic        match;
        logic [1:0]  status;
        logic [6:0]  range_count;
    } out_item_t;
endpackage
`default_nettype wire

@@ design/port_and_address_range_filter_top.sv @@
// Top level of the port and address range filter.
// Usage:
//   A command is transferred at a clock edge with start high and busy low.
//   func selects add (insert and merge a range) or query (port window and
//   address lookup). One result appears on res for one cycle with done high;
//   the receiver cannot stall it.
//   Configuration: cfg_we, cfg_index (0 port_low, 1 port_high), cfg_data.
//   Operation: a sequencer walks the stored ranges one entry at a time
//   through a single range RAM read port. A query scans all n stored
//   ranges; an add scans, then shifts or compacts the tail one entry
//   at a time.
//   One item at a time: busy stays high until the item is done.
//   Reset clears the count and opens the port window to 0..FFFF; RAM contents
//   stay undefined and are only used below the count.
`default_nettype none
module port_and_address_range_filter_top #(
    parameter int MAX_RANGES = parf_pkg::MAX_RANGES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire parf_pkg::in_item_t  cmd,
    output logic                     done,
    output parf_pkg::out_item_t      res,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import parf_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QCMP, S_LORD, S_LOCMP, S_HIRD, S_HICMP,
        S_INS_RD, S_INS_WR, S_MRG, S_CMP_RD, S_CMP_WR, S_DONE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg, lo_reg, hi_reg;
    logic [15:0]     plo_reg, phi_reg;
    in_item_t        cmd_reg;
    logic [31:0]     ms_reg;
    logic            hit_reg;
    logic [1:0]      st_reg;
    logic            done_reg;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [63:0]     wdata, rdata;
    logic [31:0]     rd_s, rd_e;

    assign rd_s = rdata[63:32];
    assign rd_e = rdata[31:0];

    parf_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Drive RAM ports from the sequencer.
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_INS_RD: raddr = AW'(idx_reg - 1'b1);
            S_INS_WR:
            begin
                we = 1'b1;
                if (idx_reg == lo_reg)
                begin
                    wdata = {cmd_reg.range_start, cmd_reg.range_end};
                end
            end
            S_MRG:
            begin
                we    = 1'b1;
                waddr = lo_reg[AW-1:0];
                wdata = {ms_reg, (rd_e > cmd_reg.range_end) ? rd_e : cmd_reg.range_end};
            end
            S_CMP_WR:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg - (hi_reg - lo_reg - 1'b1));
            end
            S_HIRD:  raddr = AW'(idx_reg);
            default: ;
        endcase
    end

    // Hold state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            plo_reg   <= 16'd0;
            phi_reg   <= 16'hFFFF;
            done_reg  <= 1'b0;
            cmd_reg   <= '0;
            idx_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            ms_reg    <= '0;
            hit_reg   <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            done_reg <= (state_reg == S_DONE);
            if (cfg_we)
            begin
                if (cfg_index == CFG_PORT_LOW) plo_reg <= cfg_data;
                else                           phi_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        st_reg  <= ST_OK;
                        if (cmd.func == FUNC_QUERY)
                        begin
                            state_reg <= S_QRD;
                        end
                        else if (cmd.range_start > cmd.range_end)
                        begin
                            st_reg    <= ST_REVERSED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LORD;
                        end
                    end
                end
                // Query: scan ranges for the address.
                S_QRD: state_reg <= (idx_reg == count_reg) ? S_DONE : S_QCMP;
                S_QCMP:
                begin
                    if (rd_s <= cmd_reg.query_addr && cmd_reg.query_addr <= rd_e)
                    begin
                        hit_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_QRD;
                end
                // Add: find first range whose end reaches the start.
                S_LORD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        lo_reg    <= idx_reg;
                        hi_reg    <= idx_reg;
                        state_reg <= S_HICMP;
                    end
                    else state_reg <= S_LOCMP;
                end
                S_LOCMP:
                begin
                    if (rd_e < cmd_reg.range_start)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LORD;
                    end
                    else
                    begin
                        lo_reg    <= idx_reg;
                        ms_reg    <= (rd_s < cmd_reg.range_start) ? rd_s
                                                                 : cmd_reg.range_start;
                        state_reg <= S_HIRD;
                    end
                end
                // Find first range that starts beyond the end.
                S_HIRD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        hi_reg    <= idx_reg;
                        state_reg <= S_HICMP;
                    end
                    else state_reg <= S_HICMP;
                end
                S_HICMP:
                begin
                    if (idx_reg != count_reg && rd_s <= cmd_reg.range_end)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_HIRD;
                    end
                    else
                    begin
                        hi_reg <= idx_reg;
                        if (idx_reg == lo_reg)
                        begin
                            if (count_reg >= CW'(MAX_RANGES))
                            begin
                                st_reg    <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= count_reg;
                                state_reg <= S_INS_RD;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_CMP_RD;
                        end
                    end
                end
                // Shift the tail up one entry and drop in the new range.
                S_INS_RD: state_reg <= S_INS_WR;
                S_INS_WR:
                begin
                    if (idx_reg == lo_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                // Merge and compact: at idx = hi-1 the last overlapping entry is read; later entries move down.
                S_CMP_RD:
                begin
                    if (idx_reg == hi_reg - 1'b1)
                    begin
                        state_reg <= S_MRG;
                    end
                    else if (idx_reg == count_reg)
                    begin
                        count_reg <= count_reg - (hi_reg - lo_reg - 1'b1);
                        state_reg <= S_DONE;
                    end
                    else state_reg <= S_CMP_WR;
                end
                S_MRG:
                begin
                    idx_reg   <= hi_reg;
                    state_reg <= S_CMP_RD;
                end
                S_CMP_WR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_CMP_RD;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res.match = hit_reg && (cmd_reg.query_port >= plo_reg)
                       && (cmd_reg.query_port <= phi_reg);
    assign res.status = st_reg;
    assign res.range_count = COUNT_W'(count_reg);
endmodule
`default_nettype wire

@@ design/parf_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module parf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/parf_checker.sv @@
// Port-level checker for the range filter, bound to the top level.
`default_nettype none
module parf_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire parf_pkg::out_item_t res
);
    import parf_pkg::*;

    // A result only shows once the sequencer is idle again.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("command not taken");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.status != 2'd3) && !(res.match && res.status != ST_OK))
        else $error("bad result code");
endmodule

bind port_and_address_range_filter_top parf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .res(res)
);
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the port and address range filter: scoreboard against a range-set predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import parf_pkg::*;

    localparam int TABLE_DEPTH = MAX_RANGES_DEF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    cmd;
    logic        done;
    out_item_t   res;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    port_and_address_range_filter_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state: port window and sorted disjoint address ranges
    logic [15:0] win_low;
    logic [15:0] win_high;
    logic [31:0] set_lo[TABLE_DEPTH];
    logic [31:0] set_hi[TABLE_DEPTH];
    int          set_size;

    in_item_t    pending_cmds[$];
    out_item_t   expected_results[$];
    int          sender_idle_pct;
    int          error_count;

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic status_t insert_range(logic [31:0] s, logic [31:0] e);
        int lo;
        int hi;
        int removed;
        logic [31:0] ms;
        logic [31:0] me;
        lo = 0;
        while (lo < set_size && set_hi[lo] < s) lo++;
        hi = lo;
        while (hi < set_size && set_lo[hi] <= e) hi++;
        if (lo == hi) begin
            if (set_size >= TABLE_DEPTH) return ST_FULL;
            for (int i = set_size; i > lo; i--) begin
                set_lo[i] = set_lo[i-1];
                set_hi[i] = set_hi[i-1];
            end
            set_lo[lo] = s;
            set_hi[lo] = e;
            set_size++;
            return ST_OK;
        end
        ms = (set_lo[lo] < s) ? set_lo[lo] : s;
        me = (set_hi[hi-1] > e) ? set_hi[hi-1] : e;
        set_lo[lo] = ms;
        set_hi[lo] = me;
        removed = hi - lo - 1;
        for (int i = hi; i < set_size; i++) begin
            set_lo[i-removed] = set_lo[i];
            set_hi[i-removed] = set_hi[i];
        end
        set_size -= removed;
        return ST_OK;
    endfunction

    function automatic out_item_t filter_predict(in_item_t c);
        out_item_t r;
        r = '0;
        if (c.func == FUNC_ADD) begin
            if (c.range_start > c.range_end) r.status = ST_REVERSED;
            else r.status = insert_range(c.range_start, c.range_end);
        end else begin
            if (c.query_port >= win_low && c.query_port <= win_high) begin
                for (int i = 0; i < set_size; i++)
                    if (set_lo[i] <= c.query_addr && c.query_addr <= set_hi[i])
                        r.match = 1'b1;
            end
        end
        r.range_count = set_size[6:0];
        return r;
    endfunction

    function automatic in_item_t random_cmd();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(in_item_t)-1:0];
    endfunction

    function automatic void queue_cmd(in_item_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Transfer bookkeeping sampled at the rising edge
    bit   cmd_taken;
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            expected_results.insert(expected_results.size(), filter_predict(cmd));
    end

    // Driver: present pending commands at the falling edge
    always @(negedge clk)
    begin
        if (cmd_taken || !start) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                cmd <= pending_cmds.pop_front();
            end else begin
                start <= 1'b0;
                cmd <= random_cmd();
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, res);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (res.match !== want.match)
                    $display("%0t: match expected %0d actual %0d", $time,
                             want.match, res.match);
                if (res.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, res.status);
                if (res.range_count !== want.range_count)
                    $display("%0t: range_count expected %0d actual %0d", $time,
                             want.range_count, res.range_count);
                if (res !== want) error_count++;
            end
        end
    end

    function automatic in_item_t make_add(logic [31:0] s, logic [31:0] e);
        in_item_t c;
        c = random_cmd();
        c.func = FUNC_ADD;
        c.range_start = s;
        c.range_end = e;
        return c;
    endfunction

    function automatic in_item_t make_query(logic [15:0] p, logic [31:0] a);
        in_item_t c;
        c = random_cmd();
        c.func = FUNC_QUERY;
        c.query_port = p;
        c.query_addr = a;
        return c;
    endfunction

    // Wait until the block has drained every command
    task automatic drain();
        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (3 * TABLE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_data <= 16'($urandom);
        if (idx == CFG_PORT_LOW) win_low = val;
        else win_high = val;
    endtask

    // Random item: adds, mostly structured into a clustered space, plus queries
    function automatic in_item_t random_item(int mode);
        logic [31:0] s;
        logic [31:0] len;
        logic [31:0] base;
        int k;
        k = $urandom_range(99);
        base = (mode == 0) ? 32'h0 : $urandom;
        if (k < 45) begin
            if ($urandom_range(9) == 0) begin
                s = $urandom;
                return make_add(s, $urandom);
            end
            s = base + $urandom_range(4000);
            len = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom_range(30);
            return make_add(s, s + len);
        end
        if ($urandom_range(3) == 0 || set_size == 0)
            return make_query(16'($urandom),
                              ($urandom_range(1)) ? $urandom : base + $urandom_range(4300));
        k = $urandom_range(set_size - 1);
        return make_query(16'($urandom), set_lo[k] + $urandom_range(2) - 1);
    endfunction

    initial
    begin
        int idle_plan[4];
        idle_plan = '{0, 53, 0, 35};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_PORT_LOW;
        cfg_data = '0;
        error_count = 0;
        sender_idle_pct = 0;
        win_low = 16'd0;
        win_high = 16'hFFFF;
        set_size = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset window, extremes, adjacency, reversal, merge spans
        queue_cmd(make_query(16'd0, 32'd0));
        queue_cmd(make_add(32'hFFFFFFFF, 32'h0));
        queue_cmd(make_add(32'd0, 32'd0));
        queue_cmd(make_add(32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_cmd(make_add(32'd1, 32'd9));
        queue_cmd(make_add(32'd20, 32'd29));
        queue_cmd(make_add(32'd10, 32'd19));
        queue_cmd(make_query(16'hFFFF, 32'd10));
        queue_cmd(make_add(32'd9, 32'd20));
        queue_cmd(make_query(16'd0, 32'hFFFFFFFF));
        queue_cmd(make_query(16'd80, 32'h7FFFFFFF));
        queue_cmd(make_add(32'd0, 32'hFFFFFFFF));
        queue_cmd(make_query(16'h5555, 32'hAAAAAAAA));
        drain();

        write_reg(CFG_PORT_LOW, 16'hFFFF);
        write_reg(CFG_PORT_HIGH, 16'd0);
        queue_cmd(make_query(16'd0, 32'd5));
        queue_cmd(make_query(16'hFFFF, 32'd5));
        drain();
        write_reg(CFG_PORT_LOW, 16'd100);
        write_reg(CFG_PORT_HIGH, 16'd200);
        queue_cmd(make_query(16'd99, 32'd5));
        queue_cmd(make_query(16'd100, 32'd5));
        queue_cmd(make_query(16'd200, 32'd5));
        queue_cmd(make_query(16'd201, 32'd5));
        drain();

        // Random phases; the table refills after the full-span merge
        for (int ph = 0; ph < 8; ph++) begin
            sender_idle_pct = idle_plan[ph % 4];
            for (int n = 0; n < 240; n++) begin
                queue_cmd(random_item(ph % 2));
                if (ph == 2 && n == 120) begin
                    // Hold off until every expected result has arrived
                    drain();
                end
                while (pending_cmds.size() > 4) @(posedge clk);
            end
            // Fill the table past full with disjoint two-address ranges in phase 5
            if (ph == 5)
                for (int n = 0; n < 70; n++) begin
                    queue_cmd(make_add(32'h9000_0000 + 4 * n,
                                       32'h9000_0000 + 4 * n + 1));
                    while (pending_cmds.size() > 4) @(posedge clk);
                end
            drain();
            write_reg(CFG_PORT_LOW, 16'($urandom_range(ph * 4000)));
            write_reg(CFG_PORT_HIGH,
                      (ph == 7) ? 16'hFFFF : 16'($urandom_range(65535, 30000)));
        end
        queue_cmd(make_query(16'hFFFF, 32'h9000_0000));
        drain();
        if (error_count == 0)
            $display("port_and_address_range_filter_top test passed");
        else
            $display("port_and_address_range_filter_top test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("port_and_address_range_filter_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
